// ----- rtl/ttmq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the timer table / message queue block.
// No dependencies; every other rtl file imports this package.
package ttmq_pkg;

  localparam int unsigned CMD_FIFO_DEPTH = 2;
  localparam logic [2:0]  CNT_SAT        = 3'd7;
  localparam logic [7:0]  EXPIRY_CODE_RST = 8'd1;

  // Raw request codes on the input channel.
  localparam logic [2:0] REQ_TICK   = 3'd0;
  localparam logic [2:0] REQ_SET    = 3'd1;
  localparam logic [2:0] REQ_CANCEL = 3'd2;
  localparam logic [2:0] REQ_POST   = 3'd3;
  localparam logic [2:0] REQ_TAKE   = 3'd4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_TICK,
    OP_SET,
    OP_CANCEL,
    OP_POST,
    OP_TAKE
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_SLOT = 2'd1,
    STAT_DROPPED = 2'd2,
    STAT_EMPTY   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_SCAN,
    BK_FINISH
  } bk_state_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  process;
    logic [7:0]  tmr_tag;
    logic [31:0] delay;
    logic [7:0]  msg_num;
    logic [31:0] msg_word;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  target;
    logic [7:0]  number;
    logic [31:0] data;
  } msg_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  process;
    logic [7:0]  msg_num;
    logic [31:0] msg_word;
    logic [2:0]  expired;
    logic [2:0]  dropped;
  } res_t;

endpackage

// ----- rtl/timer_table_message_queue.sv -----
`timescale 1ns / 1ps
// Top level of the timer table / message queue block: input stage, command
// queue, execution side and the expiry message code register. Uses ttmq_pkg.
//
//  channel  handshake                  payload
//  -------  -------------------------  -------------------------------------
//  in       in_valid_i / in_stall_o    req_type, process, tmr_tag, delay,
//                                      msg_num, msg_word
//  out      out_valid_o / out_stall_i  status, out_process, out_msg_num,
//                                      out_msg_word, expired_count, dropped_count
//  cfg      cfg_valid_i / cfg_ready_o  cfg_data_i (expiry message code)
//
// Steps: the execution side fetches an item from the command queue, executes
//   it and loads the result register; a tick also passes through a scan
//   state, since it walks the slots one per cycle so that each
//   expiry takes the single write port of the message ring in turn.
// The input stage and the two-entry command queue keep accepting items
//   while the execution side works or while a result waits to be taken.
// Reset: tick count, slot owners, ring pointers and all valid flags clear;
//   the expiry message code returns to 1. Ring contents are not cleared.
// Stalls: out_stall_i holds the result register and, once it is full, the
//   execution side; the queue and input stage then fill and raise in_stall_o.
module timer_table_message_queue #(
  parameter int unsigned TIMER_SLOTS = 4,
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  req_type_i,
  input  logic [7:0]  process_i,
  input  logic [7:0]  tmr_tag_i,
  input  logic [31:0] delay_i,
  input  logic [7:0]  msg_num_i,
  input  logic [31:0] msg_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  out_process_o,
  output logic [7:0]  out_msg_num_o,
  output logic [31:0] out_msg_word_o,
  output logic [2:0]  expired_count_o,
  output logic [2:0]  dropped_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);
  import ttmq_pkg::*;

  logic       push;
  logic       push_ready;
  cmd_t       front_cmd;
  cmd_t       fifo_cmd;
  logic       cmd_valid;
  logic       pop;
  res_t       res;
  logic [7:0] expiry_code_q;

  // Config writes must arrive only while idle; the block does not enforce this and always takes them.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expiry_code_q <= EXPIRY_CODE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      expiry_code_q <= cfg_data_i;
    end
  end

  // Decode and hold each accepted item until the command queue takes it.
  ttmq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .process_i    (process_i),
    .tmr_tag_i    (tmr_tag_i),
    .delay_i      (delay_i),
    .msg_num_i    (msg_num_i),
    .msg_word_i   (msg_word_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .cmd_o        (front_cmd)
  );

  // Decouple the input stage from the execution side.
  ttmq_cmd_fifo u_cmd_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .cmd_i        (front_cmd),
    .cmd_valid_o  (cmd_valid),
    .pop_i        (pop),
    .cmd_o        (fifo_cmd)
  );

  // Execute commands against the timer slots and the message ring.
  ttmq_back #(
    .TIMER_SLOTS (TIMER_SLOTS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (fifo_cmd),
    .pop_o         (pop),
    .expiry_code_i (expiry_code_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .res_o         (res)
  );

  assign status_o         = res.status;
  assign out_process_o    = res.process;
  assign out_msg_num_o    = res.msg_num;
  assign out_msg_word_o   = res.msg_word;
  assign expired_count_o  = res.expired;
  assign dropped_count_o  = res.dropped;

  // The input stage never pushes into a full command queue.
  a_no_fifo_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> push_ready)
    else $error("command pushed into full queue");

  // A dropped expiry is always also counted as expired.
  a_drop_le_expired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (dropped_count_o <= expired_count_o))
    else $error("dropped count exceeds expired count");

  // Any dropped expiry message shows up as a dropped status.
  a_drop_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && dropped_count_o != 3'd0) |-> (status_o == STAT_DROPPED))
    else $error("drops without dropped status");

  // A take from an empty ring returns all-zero message fields.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STAT_EMPTY) |->
      (out_process_o == 8'd0 && out_msg_num_o == 8'd0 && out_msg_word_o == 32'd0))
    else $error("empty take carries data");

endmodule

// ----- rtl/ttmq_front.sv -----
`timescale 1ns / 1ps
// Input stage: accepts request items, decodes them into commands and hands
// them to the command queue. Depends on ttmq_pkg.
module ttmq_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [2:0]      req_type_i,
  input  logic [7:0]      process_i,
  input  logic [7:0]      tmr_tag_i,
  input  logic [31:0]     delay_i,
  input  logic [7:0]      msg_num_i,
  input  logic [31:0]     msg_word_i,
  output logic            push_o,
  input  logic            push_ready_i,
  output ttmq_pkg::cmd_t  cmd_o
);
  import ttmq_pkg::*;

  logic valid_q, valid_d;
  cmd_t cmd_q;
  cmd_t cmd_dec;
  logic accept;

  // A set with no owner changes nothing and reports ok: same as an unused code.
  always_comb begin
    cmd_dec          = '0;
    cmd_dec.process  = process_i;
    cmd_dec.tmr_tag  = tmr_tag_i;
    cmd_dec.delay    = delay_i;
    cmd_dec.msg_num  = msg_num_i;
    cmd_dec.msg_word = msg_word_i;
    case (req_type_i)
      REQ_TICK:   cmd_dec.op = OP_TICK;
      REQ_SET:    cmd_dec.op = (process_i != 8'd0) ? OP_SET : OP_NONE;
      REQ_CANCEL: cmd_dec.op = OP_CANCEL;
      REQ_POST:   cmd_dec.op = OP_POST;
      REQ_TAKE:   cmd_dec.op = OP_TAKE;
      default:    cmd_dec.op = OP_NONE;
    endcase
  end

  assign push_o     = valid_q && push_ready_i;
  assign in_stall_o = valid_q && !push_ready_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign cmd_o      = cmd_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_dec;
    end
  end

endmodule

// ----- rtl/ttmq_cmd_fifo.sv -----
`timescale 1ns / 1ps
// Short command queue between the input stage and the execution side.
// Depends on ttmq_pkg.
module ttmq_cmd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              push_ready_o,
  input  ttmq_pkg::cmd_t    cmd_i,
  output logic              cmd_valid_o,
  input  logic              pop_i,
  output ttmq_pkg::cmd_t    cmd_o
);
  import ttmq_pkg::*;

  localparam int unsigned PtrW = $clog2(CMD_FIFO_DEPTH);
  localparam int unsigned CntW = $clog2(CMD_FIFO_DEPTH + 1);

  cmd_t            entry_q [CMD_FIFO_DEPTH];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign push_ready_o = cnt_q != CntW'(CMD_FIFO_DEPTH);
  assign cmd_valid_o  = cnt_q != '0;
  assign pop          = pop_i && cmd_valid_o;
  assign cmd_o        = entry_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = rptr_q + 1'b1;
    end
    case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= cmd_i;
    end
  end

endmodule

// ----- rtl/ttmq_back.sv -----
`timescale 1ns / 1ps
// Execution side: tick counter, timer slots, message ring memory and the
// result register. Depends on ttmq_pkg.
module ttmq_back #(
  parameter int unsigned TIMER_SLOTS = 4,
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  ttmq_pkg::cmd_t    cmd_i,
  output logic              pop_o,
  input  logic [7:0]        expiry_code_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ttmq_pkg::res_t    res_o
);
  import ttmq_pkg::*;

  localparam int unsigned SlotW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int unsigned QPtrW = $clog2(QUEUE_DEPTH);

  bk_state_e state_q, state_d;

  cmd_t        cmd_q;
  res_t        res_q, res_d;
  res_t        out_q, out_d;
  logic        out_valid_q;
  logic        take_hit_q;
  logic [31:0] count_q;
  logic [SlotW-1:0] idx_q;

  logic [7:0]  owner_q  [TIMER_SLOTS];
  logic [7:0]  tid_q    [TIMER_SLOTS];
  logic [31:0] expiry_q [TIMER_SLOTS];

  msg_t             mem [QUEUE_DEPTH];
  msg_t             rd_q;
  logic [QPtrW-1:0] wptr_q, rptr_q;
  logic [QPtrW-1:0] wptr_nxt, rptr_nxt;
  logic             q_full, q_empty;

  logic             free_found;
  logic [SlotW-1:0] free_idx;
  logic             hit;
  logic             scan_last;
  logic             out_free;
  logic             push_en;
  msg_t             push_msg;
  logic             rd_en;
  logic             out_load;

  assign wptr_nxt = (wptr_q == QPtrW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
  assign rptr_nxt = (rptr_q == QPtrW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
  assign q_full   = wptr_nxt == rptr_q;
  assign q_empty  = wptr_q == rptr_q;

  assign hit       = (owner_q[idx_q] != 8'd0) && (expiry_q[idx_q] == count_q);
  assign scan_last = idx_q == SlotW'(TIMER_SLOTS - 1);
  assign out_free  = !out_valid_q || !out_stall_i;

  // Lowest free slot wins.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (owner_q[i] == 8'd0) begin
        free_found = 1'b1;
        free_idx   = SlotW'(i);
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE:   if (cmd_valid_i) state_d = BK_EXEC;
      BK_EXEC:   state_d = (cmd_q.op == OP_TICK) ? BK_SCAN : BK_FINISH;
      BK_SCAN:   if (scan_last) state_d = BK_FINISH;
      BK_FINISH: if (out_free) state_d = BK_IDLE;
      default:   state_d = BK_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    pop_o    = 1'b0;
    push_en  = 1'b0;
    push_msg = '0;
    rd_en    = 1'b0;
    out_load = 1'b0;
    case (state_q)
      BK_IDLE: pop_o = cmd_valid_i;
      BK_EXEC: begin
        push_en         = (cmd_q.op == OP_POST) && !q_full;
        push_msg.target = cmd_q.process;
        push_msg.number = cmd_q.msg_num;
        push_msg.data   = cmd_q.msg_word;
        rd_en           = cmd_q.op == OP_TAKE;
      end
      BK_SCAN: begin
        push_en         = hit && !q_full;
        push_msg.target = owner_q[idx_q];
        push_msg.number = expiry_code_i;
        push_msg.data   = {24'd0, tid_q[idx_q]};
      end
      BK_FINISH: out_load = out_free;
      default: ;
    endcase
  end

  // Result of the item in progress: clear and set the status on execute, count expiries and drops on scan.
  always_comb begin
    res_d = res_q;
    case (state_q)
      BK_EXEC: begin
        res_d = '0;
        case (cmd_q.op)
          OP_SET:  if (!free_found) res_d.status = STAT_NO_SLOT;
          OP_POST: if (q_full) res_d.status = STAT_DROPPED;
          OP_TAKE: if (q_empty) res_d.status = STAT_EMPTY;
          default: ;
        endcase
      end
      BK_SCAN: begin
        if (hit) begin
          if (res_q.expired != CNT_SAT) begin
            res_d.expired = res_q.expired + 3'd1;
          end
          if (q_full) begin
            res_d.status = STAT_DROPPED;
            if (res_q.dropped != CNT_SAT) begin
              res_d.dropped = res_q.dropped + 3'd1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Merge the message read from the ring into a successful take.
  always_comb begin
    out_d = res_q;
    if (take_hit_q) begin
      out_d.process  = rd_q.target;
      out_d.msg_num  = rd_q.number;
      out_d.msg_word = rd_q.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      count_q     <= '0;
      wptr_q      <= '0;
      rptr_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < TIMER_SLOTS; i++) begin
        owner_q[i] <= 8'd0;
      end
    end else begin
      state_q <= state_d;
      if (push_en) begin
        wptr_q <= wptr_nxt;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        BK_EXEC: begin
          case (cmd_q.op)
            OP_TICK: count_q <= count_q + 32'd1;
            OP_SET: begin
              if (free_found) begin
                owner_q[free_idx] <= cmd_q.process;
              end
            end
            OP_CANCEL: begin
              for (int i = 0; i < TIMER_SLOTS; i++) begin
                if (tid_q[i] == cmd_q.tmr_tag) begin
                  owner_q[i] <= 8'd0;
                end
              end
            end
            OP_TAKE: begin
              if (!q_empty) begin
                rptr_q <= rptr_nxt;
              end
            end
            default: ;
          endcase
        end
        BK_SCAN: begin
          if (hit) begin
            owner_q[idx_q] <= 8'd0;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload: command, slot contents, result, ring memory.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
    if (push_en) begin
      mem[wptr_q] <= push_msg;
    end
    if (rd_en) begin
      rd_q <= mem[rptr_q];
    end
    res_q <= res_d;
    case (state_q)
      BK_EXEC: begin
        idx_q      <= '0;
        take_hit_q <= (cmd_q.op == OP_TAKE) && !q_empty;
        if ((cmd_q.op == OP_SET) && free_found) begin
          tid_q[free_idx]    <= cmd_q.tmr_tag;
          expiry_q[free_idx] <= cmd_q.delay + count_q;
        end
      end
      BK_SCAN: idx_q <= idx_q + 1'b1;
      default: ;
    endcase
    if (out_load) begin
      out_q <= out_d;
    end
  end

endmodule

// ----- verif/timer_table_message_queue_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for timer_table_message_queue: directed and random
// requests, in-order checking of every reply. Depends on rtl/ttmq_pkg.sv and rtl/timer_table_message_queue.sv.
module timer_table_message_queue_tb;
  import ttmq_pkg::*;

  localparam int unsigned TIMER_SLOTS = 4;
  localparam int unsigned QUEUE_DEPTH = 8;
  localparam logic [2:0]  REQ_UNUSED_LO = 3'd5;
  localparam logic [2:0]  REQ_UNUSED_HI = 3'd7;
  localparam int unsigned HOLDOFF_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 170;
  localparam int unsigned SETTLE_CYCLES = 12;

  typedef struct {
    logic [2:0]  req_type;
    logic [7:0]  process;
    logic [7:0]  tmr_tag;
    logic [31:0] delay;
    logic [7:0]  msg_num;
    logic [31:0] msg_word;
  } request_t;

  // Ports of the block; every input starts at a known value.
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  req_type_i = REQ_TICK;
  logic [7:0]  process_i = '0;
  logic [7:0]  tmr_tag_i = '0;
  logic [31:0] delay_i = '0;
  logic [7:0]  msg_num_i = '0;
  logic [31:0] msg_word_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [7:0]  out_process_o;
  logic [7:0]  out_msg_num_o;
  logic [31:0] out_msg_word_o;
  logic [2:0]  expired_count_o;
  logic [2:0]  dropped_count_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i = '0;

  timer_table_message_queue #(
    .TIMER_SLOTS(TIMER_SLOTS),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .process_i        (process_i),
    .tmr_tag_i        (tmr_tag_i),
    .delay_i          (delay_i),
    .msg_num_i        (msg_num_i),
    .msg_word_i       (msg_word_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .out_process_o    (out_process_o),
    .out_msg_num_o    (out_msg_num_o),
    .out_msg_word_o   (out_msg_word_o),
    .expired_count_o  (expired_count_o),
    .dropped_count_o  (dropped_count_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Timer table and message ring as the testbench sees them. Updated when an
  // item is accepted, so the replies come out in acceptance order.
  // ---------------------------------------------------------------------------
  logic [7:0]  expiry_code = EXPIRY_CODE_RST;
  logic [31:0] ticks = '0;
  logic [7:0]  owner    [TIMER_SLOTS] = '{default: '0};
  logic [7:0]  armed_id [TIMER_SLOTS] = '{default: '0};
  logic [31:0] fire_at  [TIMER_SLOTS] = '{default: '0};
  logic [7:0]  ring_target [QUEUE_DEPTH];
  logic [7:0]  ring_number [QUEUE_DEPTH];
  logic [31:0] ring_data   [QUEUE_DEPTH];
  int unsigned ring_wr = 0;
  int unsigned ring_rd = 0;

  // Ring holds QUEUE_DEPTH-1 messages; return 0 when the message is dropped.
  function automatic bit ring_push(logic [7:0] target, logic [7:0] number,
                                   logic [31:0] data);
    int unsigned nxt;
    nxt = (ring_wr + 1) % QUEUE_DEPTH;
    if (nxt == ring_rd) return 1'b0;
    ring_target[ring_wr] = target;
    ring_number[ring_wr] = number;
    ring_data[ring_wr]   = data;
    ring_wr = nxt;
    return 1'b1;
  endfunction

  function automatic res_t apply_request(request_t rq);
    res_t        r;
    int unsigned fired;
    int unsigned lost;
    bit          placed;
    r = '0;
    fired = 0;
    lost = 0;
    placed = 1'b0;
    case (rq.req_type)
      REQ_TICK: begin
        ticks = ticks + 32'd1;
        // Walk the slots in order; a dropped expiry still frees its slot.
        for (int s = 0; s < TIMER_SLOTS; s++) begin
          if (owner[s] != 8'd0 && fire_at[s] == ticks) begin
            if (fired < 7) fired++;
            if (!ring_push(owner[s], expiry_code, {24'd0, armed_id[s]}))
              if (lost < 7) lost++;
            owner[s] = 8'd0;
          end
        end
        if (lost != 0) r.status = STAT_DROPPED;
        r.expired = 3'(fired);
        r.dropped = 3'(lost);
      end
      REQ_SET: begin
        // Owner zero arms nothing and still reports ok.
        if (rq.process != 8'd0) begin
          for (int s = 0; s < TIMER_SLOTS; s++) begin
            if (!placed && owner[s] == 8'd0) begin
              owner[s]    = rq.process;
              armed_id[s] = rq.tmr_tag;
              fire_at[s]  = rq.delay + ticks;
              placed = 1'b1;
            end
          end
          if (!placed) r.status = STAT_NO_SLOT;
        end
      end
      REQ_CANCEL: begin
        for (int s = 0; s < TIMER_SLOTS; s++)
          if (armed_id[s] == rq.tmr_tag) owner[s] = 8'd0;
      end
      REQ_POST: begin
        if (!ring_push(rq.process, rq.msg_num, rq.msg_word)) r.status = STAT_DROPPED;
      end
      REQ_TAKE: begin
        if (ring_rd == ring_wr) begin
          r.status = STAT_EMPTY;
        end else begin
          r.process  = ring_target[ring_rd];
          r.msg_num  = ring_number[ring_rd];
          r.msg_word = ring_data[ring_rd];
          ring_rd = (ring_rd + 1) % QUEUE_DEPTH;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared state of stimulus, driver and monitor.
  // ---------------------------------------------------------------------------
  request_t request_q[$];
  res_t     expected_replies[$];
  request_t offered;
  bit       offer_pending = 1'b0;
  bit       rx_hold = 1'b0;
  bit       holdoff_go = 1'b0;
  bit       holdoff_done = 1'b0;
  int       tx_idle_pct = 0;
  int       rx_stall_pct = 0;
  int       errors = 0;
  int       requests_accepted = 0;
  int       replies_checked = 0;
  int       expiries_seen = 0;
  int       drop_replies = 0;
  int       no_slot_replies = 0;
  int       empty_takes = 0;

  // Driver: hold a stalled item, otherwise offer the next one or idle.
  always @(posedge clk_i) begin : sender
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_replies.push_back(apply_request(offered));
        requests_accepted++;
        offer_pending = 1'b0;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (request_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          offered = request_q.pop_front();
          offer_pending = 1'b1;
          in_valid_i   <= 1'b1;
          req_type_i   <= offered.req_type;
          process_i    <= offered.process;
          tmr_tag_i    <= offered.tmr_tag;
          delay_i      <= offered.delay;
          msg_num_i    <= offered.msg_num;
          msg_word_i   <= offered.msg_word;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  // Monitor: stall at random or during a hold-off, check every reply taken.
  always @(posedge clk_i) begin : receiver
    res_t want;
    out_stall_i <= rx_hold || ($urandom_range(99) < rx_stall_pct);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_replies.size() == 0) begin
        errors++;
        $display("%0t ns: reply with none expected, status %0d", $time, status_o);
      end else begin
        want = expected_replies.pop_front();
        check_field("status", want.status, status_o);
        check_field("out_process", want.process, out_process_o);
        check_field("out_msg_num", want.msg_num, out_msg_num_o);
        check_field("out_msg_word", want.msg_word, out_msg_word_o);
        check_field("expired_count", want.expired, expired_count_o);
        check_field("dropped_count", want.dropped, dropped_count_o);
        replies_checked++;
        expiries_seen += want.expired;
        if (want.status == STAT_DROPPED) drop_replies++;
        if (want.status == STAT_NO_SLOT) no_slot_replies++;
        if (want.status == STAT_EMPTY) empty_takes++;
      end
    end
  end

  // Hold-off: once started, keep the receiver stalled for a while, then flag the hold-off as done.
  initial begin : holdoff
    wait (holdoff_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLDOFF_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
    holdoff_done <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic push_request(input logic [2:0] kind, input logic [7:0] proc,
                              input logic [7:0] id, input logic [31:0] dly,
                              input logic [7:0] num, input logic [31:0] data);
    request_t rq;
    rq.req_type = kind;
    rq.process = proc;
    rq.tmr_tag = id;
    rq.delay = dly;
    rq.msg_num = num;
    rq.msg_word = data;
    request_q.push_back(rq);
  endtask

  // Mix is close to balanced so the ring wanders between empty and full.
  // Timer ids come mostly from a small pool so cancels hit armed slots,
  // and delays are mostly short so timers actually fire.
  function automatic request_t draw_request();
    request_t rq;
    int       pick;
    rq.process  = 8'($urandom_range(255));
    rq.tmr_tag  = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                           : 8'($urandom_range(7));
    rq.delay    = ($urandom_range(19) == 0) ? 32'($urandom) : 32'($urandom_range(6));
    rq.msg_num  = 8'($urandom_range(255));
    rq.msg_word = 32'($urandom);
    pick = $urandom_range(99);
    if (pick < 28) begin
      rq.req_type = REQ_TICK;
    end else if (pick < 44) begin
      rq.req_type = REQ_SET;
      if ($urandom_range(9) != 0 && rq.process == 8'd0) rq.process = 8'd1;
      // Keep far-off timers on pool ids so a later cancel frees them.
      if (rq.delay > 32'd6) rq.tmr_tag = 8'($urandom_range(7));
    end else if (pick < 52) begin
      rq.req_type = REQ_CANCEL;
    end else if (pick < 66) begin
      rq.req_type = REQ_POST;
    end else if (pick < 98) begin
      rq.req_type = REQ_TAKE;
    end else begin
      rq.req_type = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
    end
    return rq;
  endfunction

  // Wait until every item is sent and every reply is in, then let the
  // longest item (a tick walking all slots) settle.
  task automatic drain();
    while (request_q.size() != 0 || offer_pending || expected_replies.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_expiry_code(input logic [7:0] code);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= code;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    expiry_code = code;
  endtask

  task automatic set_pace(input int tx_pct, input int rx_pct);
    @(posedge clk_i);
    tx_idle_pct  <= tx_pct;
    rx_stall_pct <= rx_pct;
  endtask

  task automatic random_phase(input logic [7:0] code, input int tx_pct,
                              input int rx_pct);
    write_expiry_code(code);
    set_pace(tx_pct, rx_pct);
    repeat (PHASE_ITEMS) request_q.push_back(draw_request());
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: reset value of the expiry code, no idling.
    push_request(REQ_TAKE,   8'h00, 8'h00, 32'h0, 8'h00, 32'h0);        // empty ring
    push_request(REQ_SET,    8'h00, 8'h44, 32'h1, 8'h00, 32'h0);        // owner zero
    push_request(REQ_SET,    8'hFF, 8'hFF, 32'h2, 8'h00, 32'h0);
    push_request(REQ_SET,    8'h01, 8'h00, 32'h2, 8'h00, 32'h0);
    push_request(REQ_SET,    8'h80, 8'hAA, 32'h2, 8'h00, 32'h0);
    push_request(REQ_SET,    8'h07, 8'h55, 32'h2, 8'h00, 32'h0);
    push_request(REQ_SET,    8'h09, 8'h12, 32'h2, 8'h00, 32'h0);        // table full
    push_request(REQ_CANCEL, 8'h00, 8'h55, 32'h0, 8'h00, 32'h0);
    push_request(REQ_CANCEL, 8'h00, 8'h33, 32'h0, 8'h00, 32'h0);        // matches nothing
    push_request(REQ_POST,   8'h00, 8'h00, 32'h0, 8'hFF, 32'hFFFF_FFFF); // target zero
    push_request(REQ_POST,   8'hFF, 8'h00, 32'h0, 8'h00, 32'h0);
    push_request(REQ_POST,   8'h5A, 8'h00, 32'h0, 8'hA5, 32'hA5A5_5A5A);
    push_request(REQ_POST,   8'hA5, 8'h00, 32'h0, 8'h5A, 32'h5A5A_A5A5);
    push_request(REQ_POST,   8'h11, 8'h00, 32'h0, 8'h22, 32'h3333_4444);
    push_request(REQ_TICK,   8'h00, 8'h00, 32'h0, 8'h00, 32'h0);
    push_request(REQ_TICK,   8'h00, 8'h00, 32'h0, 8'h00, 32'h0);        // three fire, one drops
    push_request(REQ_POST,   8'h66, 8'h00, 32'h0, 8'h77, 32'h8888_9999); // ring full
    repeat (4) push_request(REQ_TAKE, 8'h00, 8'h00, 32'h0, 8'h00, 32'h0);
    push_request(REQ_SET,    8'h03, 8'h0F, 32'h0, 8'h00, 32'h0);        // zero delay
    push_request(REQ_SET,    8'hFE, 8'h0F, 32'hFFFF_FFFF, 8'h00, 32'h0); // wraps
    push_request(REQ_CANCEL, 8'h00, 8'h0F, 32'h0, 8'h00, 32'h0);        // frees both
    push_request(REQ_UNUSED_HI, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
    drain();

    // Random phases, each with its own expiry code and idling pattern.
    random_phase(8'hFF, 0, 0);
    random_phase(8'h00, 48, 0);
    random_phase(8'hA5, 0, 48);
    random_phase(8'h5A, 13, 13);

    // Back-pressure: hold the receiver off while the sender keeps offering,
    // so the block fills and stalls its input.
    write_expiry_code(EXPIRY_CODE_RST);
    set_pace(0, 0);
    holdoff_go <= 1'b1;
    repeat (60) request_q.push_back(draw_request());
    wait (holdoff_done);
    set_pace(13, 48);
    repeat (PHASE_ITEMS / 2) request_q.push_back(draw_request());
    drain();

    $display("Checked %0d replies to %0d requests: %0d timer expiries, %0d drops,",
             replies_checked, requests_accepted, expiries_seen, drop_replies);
    $display("%0d set requests without a free slot, %0d takes from an empty ring.",
             no_slot_replies, empty_takes);
    if (errors == 0 && expected_replies.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("Timeout with %0d replies outstanding", expected_replies.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
